// ----- rtl/core/csort_pkg.sv -----
// Shared types, codes and default sizes for the stable counting sort block.
`default_nettype none

package csort_pkg;

    // Default sizing of the item buffer and the histogram.
    localparam int MAX_ITEMS_DEF = 4096;
    localparam int KEY_BINS_DEF  = 1024;

    // Fixed field widths.
    localparam int KEY_W      = 32;
    localparam int PAY_W      = 32;
    localparam int SPAN_REG_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SPAN = 1'b1;

    // Input action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_LOADED   = 3'd0,
        STAT_RETURNED = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NONE     = 3'd4
    } status_t;

    // Set phase.
    typedef enum logic [1:0] {
        PH_EMPTY   = 2'd0,
        PH_LOADING = 2'd1,
        PH_SORTED  = 2'd2
    } phase_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_FETCH,
        ST_PREFIX,
        ST_SC_RD,
        ST_SC_CNT,
        ST_SC_WR
    } state_t;

    // One result item as handed from the controller to the output register.
    typedef struct packed {
        status_t                   status;
        logic signed [KEY_W-1:0]   sorted_key;
        logic        [PAY_W-1:0]   sorted_payload;
        logic                      final_item;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/csort_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface csort_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic signed [31:0] key;
    logic [31:0] payload;
    logic        last_item;

    modport source (output valid, action, key, payload, last_item, input ready);
    modport sink   (input valid, action, key, payload, last_item, output ready);
endinterface

interface csort_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] sorted_key;
    logic [31:0] sorted_payload;
    logic        final_item;

    modport source (output valid, status, sorted_key, sorted_payload, final_item,
                    input ready);
    modport sink   (input valid, status, sorted_key, sorted_payload, final_item,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/csort_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module csort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/csort_ctrl.sv -----
// Sequencer for loads, fetches and the prefix, scatter and clear passes over the two RAMs.
`default_nettype none

module csort_ctrl
    import csort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int KEY_BINS  = KEY_BINS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    csort_in_if.sink                              items,
    input  wire logic [KEY_W-1:0]                 key_min,
    input  wire logic [$clog2(KEY_BINS+1)-1:0]    span_use,
    input  wire logic                             res_ready,
    output logic                                  res_valid,
    output res_t                                  res
);

    localparam int BIN_W  = $clog2(KEY_BINS);
    localparam int BC_W   = $clog2(KEY_BINS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IAW    = IDX_W + 1;
    localparam int ITM_W  = BIN_W + PAY_W;
    localparam int ITM_DEPTH = 2 ** IAW;

    localparam logic LOADED_AREA = 1'b0;
    localparam logic SORTED_AREA = 1'b1;

    // Control and pointer registers.
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  item_count_reg, item_count_next;
    logic [CNT_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  sc_idx_reg, sc_idx_next;
    logic [BC_W-1:0]   idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [BIN_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic              hit_reg, hit_next;

    // Captured load item.
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic              bin_ok_reg, bin_ok_next;
    logic [PAY_W-1:0]  payload_reg, payload_next;
    logic              last_reg, last_next;

    // RAM ports.
    logic              cnt_wr_en, cnt_rd_en;
    logic [BIN_W-1:0]  cnt_wr_addr, cnt_rd_addr;
    logic [CNT_W-1:0]  cnt_wr_data, cnt_rd_data;
    logic              itm_wr_en, itm_rd_en;
    logic [IAW-1:0]    itm_wr_addr, itm_rd_addr;
    logic [ITM_W-1:0]  itm_wr_data, itm_rd_data;

    // Range check of an incoming key.
    logic [KEY_W:0]    diff;
    logic              in_range;
    logic [CNT_W-1:0]  eff_count;
    logic [BIN_W-1:0]  itm_bin;
    logic [PAY_W-1:0]  itm_pay;

    assign diff     = {items.key[KEY_W-1], items.key} - {key_min[KEY_W-1], key_min};
    assign in_range = !diff[KEY_W] && (diff < (KEY_W+1)'(span_use));
    assign eff_count = (phase_reg == PH_LOADING) ? item_count_reg : '0;
    assign itm_bin  = itm_rd_data[PAY_W +: BIN_W];
    assign itm_pay  = itm_rd_data[PAY_W-1:0];

    assign items.ready = (state_reg == ST_IDLE);

    // Histogram of bin counts; during sorting it holds the running slot of each bin.
    csort_ram #(
        .WIDTH (CNT_W),
        .DEPTH (KEY_BINS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // Item store: lower half in arrival order, upper half in sorted order.
    csort_ram #(
        .WIDTH (ITM_W),
        .DEPTH (ITM_DEPTH)
    ) u_itm_ram (
        .clk     (clk),
        .wr_en   (itm_wr_en),
        .wr_addr (itm_wr_addr),
        .wr_data (itm_wr_data),
        .rd_en   (itm_rd_en),
        .rd_addr (itm_rd_addr),
        .rd_data (itm_rd_data)
    );

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_EMPTY;
            item_count_reg <= '0;
            rp_reg         <= '0;
            sc_idx_reg     <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            run_reg        <= '0;
            hit_reg        <= 1'b0;
            last_reg       <= 1'b0;
            bin_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            item_count_reg <= item_count_next;
            rp_reg         <= rp_next;
            sc_idx_reg     <= sc_idx_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            run_reg        <= run_next;
            hit_reg        <= hit_next;
            last_reg       <= last_next;
            bin_ok_reg     <= bin_ok_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        payload_reg   <= payload_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Next state, RAM controls and result.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        item_count_next = item_count_reg;
        rp_next         = rp_reg;
        sc_idx_next     = sc_idx_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        run_next        = run_reg;
        hit_next        = hit_reg;
        bin_next        = bin_reg;
        bin_ok_next     = bin_ok_reg;
        payload_next    = payload_reg;
        last_next       = last_reg;

        cnt_wr_en   = 1'b0;
        cnt_wr_addr = '0;
        cnt_wr_data = '0;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = diff[BIN_W-1:0];
        itm_wr_en   = 1'b0;
        itm_wr_addr = '0;
        itm_wr_data = '0;
        itm_rd_en   = 1'b0;
        itm_rd_addr = {SORTED_AREA, rp_reg[IDX_W-1:0]};

        res_valid = 1'b0;
        res       = '{status: STAT_NONE, sorted_key: '0, sorted_payload: '0,
                      final_item: 1'b0};

        unique case (state_reg)
            // Zero the histogram, one bin a cycle.
            ST_CLEAR:
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = idx_reg[BIN_W-1:0];
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == BC_W'(KEY_BINS - 1))
                begin
                    state_next = ST_IDLE;
                    if (phase_reg == PH_LOADING)
                    begin
                        phase_next = PH_SORTED;
                        rp_next    = '0;
                    end
                end
            end

            // Take a transfer; a load starts the histogram read of its bin.
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    if (items.action == ACT_LOAD)
                    begin
                        bin_next     = diff[BIN_W-1:0];
                        bin_ok_next  = in_range;
                        payload_next = items.payload;
                        last_next    = items.last_item;
                        cnt_rd_en    = 1'b1;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        hit_next   = (phase_reg == PH_SORTED) && (rp_reg < item_count_reg);
                        itm_rd_en  = (phase_reg == PH_SORTED) && (rp_reg < item_count_reg);
                        state_next = ST_FETCH;
                    end
                end
            end

            // Report the load; if it is in range and the set is not full, store it and bump its bin count.
            ST_LOAD:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_LOADING;
                    item_count_next = eff_count;
                    if (!bin_ok_reg)
                    begin
                        res.status = STAT_RANGE;
                    end
                    else if (eff_count == CNT_W'(MAX_ITEMS))
                    begin
                        res.status = STAT_FULL;
                    end
                    else
                    begin
                        res.status      = STAT_LOADED;
                        cnt_wr_en       = 1'b1;
                        cnt_wr_addr     = bin_reg;
                        cnt_wr_data     = cnt_rd_data + 1'b1;
                        itm_wr_en       = 1'b1;
                        itm_wr_addr     = {LOADED_AREA, eff_count[IDX_W-1:0]};
                        itm_wr_data     = {bin_reg, payload_reg};
                        item_count_next = eff_count + 1'b1;
                    end
                    if (last_reg)
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        run_next   = '0;
                        state_next = ST_PREFIX;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Return the next sorted item or report that none is left.
            ST_FETCH:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    if (hit_reg)
                    begin
                        res.status         = STAT_RETURNED;
                        res.sorted_key     = key_min + KEY_W'(itm_bin);
                        res.sorted_payload = itm_pay;
                        res.final_item     = ((rp_reg + 1'b1) == item_count_reg);
                        rp_next            = rp_reg + 1'b1;
                    end
                end
            end

            // Exclusive prefix sum: read one bin while writing back the previous one.
            ST_PREFIX:
            begin
                pend_next = 1'b0;
                if (idx_reg != BC_W'(KEY_BINS))
                begin
                    cnt_rd_en      = 1'b1;
                    cnt_rd_addr    = idx_reg[BIN_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[BIN_W-1:0];
                    idx_next       = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    cnt_wr_en   = 1'b1;
                    cnt_wr_addr = pend_addr_reg;
                    cnt_wr_data = run_reg;
                    run_next    = run_reg + cnt_rd_data;
                end
                else if (idx_reg == BC_W'(KEY_BINS))
                begin
                    sc_idx_next = '0;
                    state_next  = ST_SC_RD;
                end
            end

            // Scatter: read the next item in arrival order.
            ST_SC_RD:
            begin
                if (sc_idx_reg < item_count_reg)
                begin
                    itm_rd_en   = 1'b1;
                    itm_rd_addr = {LOADED_AREA, sc_idx_reg[IDX_W-1:0]};
                    state_next  = ST_SC_CNT;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_CLEAR;
                end
            end

            // Scatter: fetch the running slot of the item's bin.
            ST_SC_CNT:
            begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = itm_bin;
                state_next  = ST_SC_WR;
            end

            // Scatter: place the item and advance its bin's slot.
            ST_SC_WR:
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = itm_bin;
                cnt_wr_data = cnt_rd_data + 1'b1;
                itm_wr_en   = 1'b1;
                itm_wr_addr = {SORTED_AREA, cnt_rd_data[IDX_W-1:0]};
                itm_wr_data = itm_rd_data;
                sc_idx_next = sc_idx_reg + 1'b1;
                state_next  = ST_SC_RD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/counting_sort_with_payload.sv -----
// Stable counting sort of signed keys with payload: configuration registers and result register.
//
// Usage: the items channel carries loads (action 0) and fetches (action 1); the results
// channel returns exactly one result per item, in order. Loads build a histogram of
// key - key_min in the count RAM and keep bin and payload in arrival order in the item RAM.
// A load with last_item set closes the set and starts sorting; fetches then return the
// items in ascending key order, ties in arrival order, with final_item on the last one.
// Flow: a load or fetch is taken in the idle state and gives its result from its load or
// fetch state through the output register; the next item is taken only once the block is
// back in idle, a pace set by the read-modify-write of one RAM entry. After the closing
// load the block takes no item during a prefix pass over all KEY_BINS bins, a scatter of
// each stored item (item RAM read, count RAM read, then both writes), and a histogram clear.
// Reset: key_min = 0, key_span = 1024, no set loaded; a clearing pass zeroes the count RAM
// before the first item is taken. Configuration writes are taken in any cycle through
// cfg_we, cfg_index and cfg_data.
// Stalls: one result waits in the output register while the next item may already be
// taken; its result then waits until the register frees up.
`default_nettype none

module counting_sort_with_payload
    import csort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int KEY_BINS  = KEY_BINS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    csort_in_if.sink                   items,
    csort_out_if.source                results,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BC_W = $clog2(KEY_BINS + 1);

    logic [KEY_W-1:0]      key_min_reg;
    logic [SPAN_REG_W-1:0] key_span_reg;
    logic [31:0]           span_wide;
    logic [BC_W-1:0]       span_use;

    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;
    logic                  out_valid_reg;
    res_t                  out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_min_reg  <= '0;
            key_span_reg <= SPAN_REG_W'(1024);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_KEY_MIN)
            begin
                key_min_reg <= cfg_data[KEY_W-1:0];
            end
            else
            begin
                key_span_reg <= cfg_data[SPAN_REG_W-1:0];
            end
        end
    end

    // Span in use: zero acts as one, anything above the bin count as the bin count.
    assign span_wide = 32'(key_span_reg);
    always_comb
    begin
        priority if (key_span_reg == '0)
        begin
            span_use = BC_W'(1);
        end
        else if (span_wide > 32'(KEY_BINS))
        begin
            span_use = BC_W'(KEY_BINS);
        end
        else
        begin
            span_use = span_wide[BC_W-1:0];
        end
    end

    csort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BINS  (KEY_BINS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .key_min   (key_min_reg),
        .span_use  (span_use),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: takes a new result when empty or when its transfer completes.
    assign res_ready = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.status         = out_data_reg.status;
    assign results.sorted_key     = out_data_reg.sorted_key;
    assign results.sorted_payload = out_data_reg.sorted_payload;
    assign results.final_item     = out_data_reg.final_item;

endmodule

`default_nettype wire

// ----- tb/counting_sort_with_payload_tb.sv -----
// Self-checking testbench for the stable counting sort block, with its own sort predictor.
module counting_sort_with_payload_tb;
    import csort_pkg::*;

    localparam int NBINS          = KEY_BINS_DEF;
    localparam int NSLOTS         = MAX_ITEMS_DEF;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 2_500_000;
    localparam int MAX_REPORTS    = 200;

    typedef struct {
        logic        action;
        logic [31:0] key;
        logic [31:0] payload;
        logic        last_item;
    } sort_item_t;

    typedef struct {
        status_t     status;
        logic [31:0] key;
        logic [31:0] payload;
        logic        final_item;
    } sort_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    csort_in_if  item_ch ();
    csort_out_if result_ch ();

    counting_sort_with_payload DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Items waiting to be offered, and sorted results still to come back.
    sort_item_t   items_to_send [$];
    sort_result_t expected_results [$];
    sort_item_t   offered_item;
    sort_result_t oldest_expected;
    int           queued_total;
    int           error_count;

    // Idling and pressure controls.
    int src_idle_pct;
    int sink_idle_pct;
    int hold_request;
    int hold_seen;
    int hold_left;

    // Predictor copy of the registers and the sort state.
    logic [31:0] key_base;
    logic [10:0] span_setting;
    int unsigned bin_tally [NBINS];
    logic [9:0]  arrival_bin [NSLOTS];
    logic [31:0] arrival_pay [NSLOTS];
    logic [9:0]  ordered_bin [NSLOTS];
    logic [31:0] ordered_pay [NSLOTS];
    int unsigned stored_count;
    int unsigned fetch_index;
    phase_t      set_phase;
    bit          sort_in_progress;
    int unsigned sorted_len;

    always #6 clk = ~clk;

    // Number of bins actually in use for a given span register value.
    function automatic int eff_span(input logic [10:0] span);
        if (span == 0)
            return 1;
        if (span > NBINS)
            return NBINS;
        return int'(span);
    endfunction

    // Work out the result of one transfer and append it to the expected results.
    task automatic predict_sort_result(input sort_item_t it);
        sort_result_t res;
        longint       offset;
        int unsigned  run;
        int unsigned  cnt;
        res.status     = STAT_NONE;
        res.key        = '0;
        res.payload    = '0;
        res.final_item = 1'b0;
        if (it.action == ACT_LOAD)
        begin
            offset = longint'($signed(it.key)) - longint'($signed(key_base));
            // A load after a finished set starts a fresh one.
            if (set_phase != PH_LOADING)
            begin
                foreach (bin_tally[b])
                    bin_tally[b] = 0;
                stored_count = 0;
                set_phase    = PH_LOADING;
            end
            if (offset < 0 || offset >= eff_span(span_setting))
                res.status = STAT_RANGE;
            else if (stored_count >= NSLOTS)
                res.status = STAT_FULL;
            else
            begin
                arrival_bin[stored_count] = offset[9:0];
                arrival_pay[stored_count] = it.payload;
                bin_tally[offset[9:0]]++;
                stored_count++;
                res.status = STAT_LOADED;
            end
            // The closing load turns the histogram into start slots and scatters stably.
            if (it.last_item)
            begin
                run = 0;
                for (int b = 0; b < NBINS; b++)
                begin
                    cnt          = bin_tally[b];
                    bin_tally[b] = run;
                    run         += cnt;
                end
                for (int i = 0; i < stored_count; i++)
                begin
                    ordered_bin[bin_tally[arrival_bin[i]]] = arrival_bin[i];
                    ordered_pay[bin_tally[arrival_bin[i]]] = arrival_pay[i];
                    bin_tally[arrival_bin[i]]++;
                end
                fetch_index      = 0;
                set_phase        = PH_SORTED;
                sorted_len       = stored_count;
                sort_in_progress = 1'b1;
            end
        end
        else if (set_phase == PH_SORTED && fetch_index < stored_count)
        begin
            res.status     = STAT_RETURNED;
            res.key        = key_base + 32'(ordered_bin[fetch_index]);
            res.payload    = ordered_pay[fetch_index];
            res.final_item = (fetch_index + 1 == stored_count);
            fetch_index++;
        end
        expected_results.push_back(res);
    endtask

    // Sender: offers queued items, idling at random, and predicts each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid     <= 1'b0;
            item_ch.action    <= ACT_LOAD;
            item_ch.key       <= '0;
            item_ch.payload   <= '0;
            item_ch.last_item <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                predict_sort_result(offered_item);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    offered_item       = items_to_send.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.action    <= offered_item.action;
                    item_ch.key       <= offered_item.key;
                    item_ch.payload   <= offered_item.payload;
                    item_ch.last_item <= offered_item.last_item;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_seen       <= 0;
            hold_left       <= 0;
        end
        else if (hold_seen != hold_request)
        begin
            hold_seen       <= hold_request;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic note_mismatch(input string field, input longint want, input longint got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Monitor: compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none expected, expected nothing, actual status %0d",
                         $time, result_ch.status);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result_ch.status !== oldest_expected.status)
                    note_mismatch("status", oldest_expected.status, result_ch.status);
                if (result_ch.sorted_key !== oldest_expected.key)
                    note_mismatch("sorted_key", oldest_expected.key, result_ch.sorted_key);
                if (result_ch.sorted_payload !== oldest_expected.payload)
                    note_mismatch("sorted_payload", oldest_expected.payload,
                                  result_ch.sorted_payload);
                if (result_ch.final_item !== oldest_expected.final_item)
                    note_mismatch("final_item", oldest_expected.final_item,
                                  result_ch.final_item);
            end
        end
    end

    task automatic queue_item(input logic action, input logic [31:0] key,
                              input logic [31:0] payload, input logic last_item);
        sort_item_t it;
        it.action    = action;
        it.key       = key;
        it.payload   = payload;
        it.last_item = last_item;
        items_to_send.push_back(it);
        queued_total++;
    endtask

    // Wait until every item is through and every result is back, then let a sort pass finish.
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (items_to_send.size() != 0 || item_ch.valid || expected_results.size() != 0);
        if (sort_in_progress)
        begin
            repeat (2 * NBINS + 3 * sorted_len + 16) @(posedge clk);
            sort_in_progress = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_MIN)
            key_base = value;
        else
            span_setting = value[10:0];
        @(negedge clk);
    endtask

    function automatic logic [31:0] key_in_range();
        return key_base + 32'($urandom_range(eff_span(span_setting) - 1, 0));
    endfunction

    function automatic logic [31:0] key_out_of_range();
        case ($urandom_range(3))
            0:       return key_base - 32'd1 - 32'($urandom_range(3));
            1:       return key_base + 32'(eff_span(span_setting)) + 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_key_min();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return $urandom;
            4:       return 32'h7FFF_FFFF - 32'($urandom_range(1100));
            default: return 32'($urandom_range(2000)) - 32'd1000;
        endcase
    endfunction

    function automatic logic [31:0] pick_span();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd1024;
            3:       return 32'd2047;
            4:       return 32'($urandom_range(16, 2));
            5:       return 32'($urandom_range(2047, 1025));
            default: return 32'($urandom_range(1023, 2));
        endcase
    endfunction

    task automatic change_settings();
        int pick;
        pick = $urandom_range(2);
        wait_for_idle();
        if (pick != 1)
            write_register(CFG_KEY_MIN, pick_key_min());
        if (pick != 0)
            write_register(CFG_KEY_SPAN, pick_span());
    endtask

    // One set: loads, usually with a closing load, some noise, then fetches (sometimes too few or too many).
    task automatic run_random_set();
        int   n_loads;
        int   n_fetches;
        logic closing;
        n_loads = $urandom_range(20, 1);
        for (int i = 0; i < n_loads; i++)
        begin
            closing = (i == n_loads - 1) && ($urandom_range(9) != 0);
            if ($urandom_range(14) == 0)
                queue_item(ACT_FETCH, $urandom, $urandom, 1'($urandom_range(1)));
            queue_item(ACT_LOAD, ($urandom_range(9) == 0) ? key_out_of_range() : key_in_range(),
                       $urandom, closing);
            // Now and then move key_min between the sort and the fetches.
            if (closing && $urandom_range(9) == 0)
            begin
                wait_for_idle();
                write_register(CFG_KEY_MIN, pick_key_min());
            end
        end
        n_fetches = n_loads + $urandom_range(2);
        if ($urandom_range(4) == 0)
            n_fetches = $urandom_range(n_loads);
        repeat (n_fetches)
            queue_item(ACT_FETCH, $urandom, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct, input int count);
        int first;
        wait_for_idle();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        first         = queued_total;
        // The receiver holds off for a long stretch while the first set streams in.
        hold_request++;
        while (queued_total - first < count)
        begin
            if ($urandom_range(3) == 0)
                change_settings();
            run_random_set();
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_KEY_MIN;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.action      = ACT_LOAD;
        item_ch.key         = '0;
        item_ch.payload     = '0;
        item_ch.last_item   = 1'b0;
        result_ch.ready     = 1'b0;
        queued_total        = 0;
        error_count         = 0;
        src_idle_pct        = 0;
        sink_idle_pct       = 0;
        hold_request        = 0;
        key_base            = 32'd0;
        span_setting        = 11'd1024;
        stored_count        = 0;
        fetch_index         = 0;
        set_phase           = PH_EMPTY;
        sort_in_progress    = 1'b0;
        sorted_len          = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its histogram after reset before it takes items.
        repeat (NBINS + 8) @(posedge clk);
        @(negedge clk);
        src_idle_pct  = 37;
        sink_idle_pct = 85;

        // Directed: fetch with nothing loaded, field extremes, ties and range edges.
        queue_item(ACT_FETCH, 32'd0, 32'd0, 1'b0);
        queue_item(ACT_LOAD, 32'd5, 32'hFFFF_FFFF, 1'b0);
        queue_item(ACT_LOAD, 32'd1023, 32'd0, 1'b0);
        queue_item(ACT_LOAD, 32'd0, 32'd1, 1'b0);
        queue_item(ACT_LOAD, 32'd5, 32'd2, 1'b0);
        queue_item(ACT_LOAD, 32'hFFFF_FFFF, 32'd3, 1'b0);
        queue_item(ACT_LOAD, 32'd1024, 32'd4, 1'b0);
        queue_item(ACT_LOAD, 32'h7FFF_FFFF, 32'd5, 1'b0);
        queue_item(ACT_LOAD, 32'h8000_0000, 32'd6, 1'b0);
        queue_item(ACT_FETCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_item(ACT_LOAD, 32'd3, 32'd7, 1'b1);
        repeat (6) queue_item(ACT_FETCH, 32'd0, 32'd0, 1'b0);

        // Most negative base; a span above the bin count acts as the full bin count.
        wait_for_idle();
        write_register(CFG_KEY_MIN, 32'h8000_0000);
        write_register(CFG_KEY_SPAN, 32'd2047);
        queue_item(ACT_LOAD, 32'h8000_0000 + 32'd1023, 32'd8, 1'b0);
        queue_item(ACT_LOAD, 32'h8000_0000 + 32'd1024, 32'd9, 1'b0);
        queue_item(ACT_LOAD, 32'h8000_0000, 32'd10, 1'b1);

        // Moving the base after the sort shifts the returned keys, wrapping at the top.
        wait_for_idle();
        write_register(CFG_KEY_MIN, 32'h7FFF_FFFF);
        write_register(CFG_KEY_SPAN, 32'd0);
        repeat (3) queue_item(ACT_FETCH, 32'd0, 32'd0, 1'b0);

        // A rejected closing load sorts an empty set; a zero span still admits one bin.
        queue_item(ACT_LOAD, 32'h7FFF_FFFE, 32'd11, 1'b1);
        queue_item(ACT_FETCH, 32'd0, 32'd0, 1'b0);
        queue_item(ACT_LOAD, 32'h7FFF_FFFF, 32'd12, 1'b1);
        repeat (2) queue_item(ACT_FETCH, 32'd0, 32'd0, 1'b0);

        // Random sets under the three idling patterns.
        run_random_phase(37, 85, 200);
        run_random_phase(85, 37, 200);
        run_random_phase(0, 0, 200);

        wait_for_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog.
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
